// ===== hw/rtl/lwo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lwo_pkg;

   localparam int unsigned FRAME_BYTES = 12;
   localparam int unsigned IDX_W       = 4;
   localparam logic [IDX_W-1:0] IDX_FIRST  = 4'd0;
   localparam logic [IDX_W-1:0] IDX_WINDOW = 4'd2;
   localparam logic [IDX_W-1:0] IDX_LAST   = 4'd11;

   localparam logic [7:0] DEF_PANEL_COLS = 8'd128;
   localparam logic [7:0] DEF_PANEL_ROWS = 8'd160;

   localparam logic [7:0] CMD_CASET  = 8'h2A;
   localparam logic [7:0] CMD_RASET  = 8'h2B;
   localparam logic [7:0] CMD_MADCTL = 8'h36;

   localparam logic [7:0] SCAN_DIR0 = 8'hC8;
   localparam logic [7:0] SCAN_DIR1 = 8'h48;
   localparam logic [7:0] SCAN_DIR2 = 8'hA8;
   localparam logic [7:0] SCAN_DIR3 = 8'h68;

   localparam logic [7:0] DIR_0 = 8'd0;
   localparam logic [7:0] DIR_1 = 8'd1;
   localparam logic [7:0] DIR_2 = 8'd2;
   localparam logic [7:0] DIR_3 = 8'd3;

   localparam logic FUNC_SET_WINDOW = 1'b0;
   localparam logic FUNC_SET_DIR    = 1'b1;

   // data/command tag per byte slot, slot 0 in bit 0
   localparam logic [FRAME_BYTES-1:0] SLOT_IS_DATA = 12'b1111_0111_1010;

   typedef struct packed {
      logic [7:0]  x_start;
      logic [7:0]  y_start;
      logic [15:0] win_width;
      logic [15:0] win_height;
      logic [7:0]  direction;
   } req_type;

   typedef struct packed {
      logic [FRAME_BYTES-1:0][7:0] bytes;
      logic [IDX_W-1:0]            start_idx;
   } frame_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lwo_frame_build.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lwo_frame_build
   import lwo_pkg::*;
#(
   parameter logic [7:0] PANEL_COLS = DEF_PANEL_COLS,
   parameter logic [7:0] PANEL_ROWS = DEF_PANEL_ROWS
) (
   input  wire logic      func,
   input  wire req_type   req,
   input  wire logic      landscape,
   output frame_type      frame,
   output logic           landscape_next
);

   logic        lan;
   logic [7:0]  scan;
   logic [15:0] sx, sy, w, h, ex, ey, ox, oy;
   logic [15:0] xs_o, xe_o, ys_o, ye_o;

   always_comb begin
      case (req.direction)
         DIR_1:   scan = SCAN_DIR1;
         DIR_2:   scan = SCAN_DIR2;
         DIR_3:   scan = SCAN_DIR3;
         default: scan = SCAN_DIR0;
      endcase
   end

   always_comb begin
      if (func == FUNC_SET_DIR) begin
         lan = (req.direction == DIR_2) || (req.direction == DIR_3);
         sx  = 16'd0;
         sy  = 16'd0;
         w   = lan ? {8'd0, PANEL_ROWS} : {8'd0, PANEL_COLS};
         h   = lan ? {8'd0, PANEL_COLS} : {8'd0, PANEL_ROWS};
      end else begin
         lan = landscape;
         sx  = {8'd0, req.x_start};
         sy  = {8'd0, req.y_start};
         w   = req.win_width;
         h   = req.win_height;
      end
   end

   assign ex   = sx + w - 16'd1;
   assign ey   = sy + h - 16'd1;
   assign ox   = lan ? 16'd3 : 16'd2;
   assign oy   = lan ? 16'd2 : 16'd3;
   assign xs_o = sx + ox;
   assign xe_o = ex + ox;
   assign ys_o = sy + oy;
   assign ye_o = ey + oy;

   assign landscape_next = lan;

   always_comb begin
      frame.bytes[0]  = CMD_MADCTL;
      frame.bytes[1]  = scan;
      frame.bytes[2]  = CMD_CASET;
      frame.bytes[3]  = xs_o[15:8];
      frame.bytes[4]  = xs_o[7:0];
      frame.bytes[5]  = xe_o[15:8];
      frame.bytes[6]  = xe_o[7:0];
      frame.bytes[7]  = CMD_RASET;
      frame.bytes[8]  = ys_o[15:8];
      frame.bytes[9]  = ys_o[7:0];
      frame.bytes[10] = ye_o[15:8];
      frame.bytes[11] = ye_o[7:0];
      frame.start_idx = (func == FUNC_SET_DIR) ? IDX_FIRST : IDX_WINDOW;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/lwo_byte_ser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lwo_byte_ser
   import lwo_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       frame_valid,
   input  wire frame_type  frame,
   output logic            frame_take,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // out_byte[7:0]
   output logic            rsp_tuser,   // is_data
   output logic            rsp_tlast
);

   logic                        busy_ff, busy_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [FRAME_BYTES-1:0][7:0] bytes_ff, bytes_in;
   logic                        rsp_fire, at_last;

   assign rsp_fire   = busy_ff && rsp_tready;
   assign at_last    = (idx_ff == IDX_LAST);
   assign frame_take = frame_valid && (!busy_ff || (rsp_fire && at_last));

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      bytes_in = bytes_ff;
      if (frame_take) begin
         busy_in  = 1'b1;
         idx_in   = frame.start_idx;
         bytes_in = frame.bytes;
      end else if (rsp_fire) begin
         if (at_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= IDX_FIRST;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      bytes_ff <= bytes_in;
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = bytes_ff[idx_ff];
   assign rsp_tuser  = SLOT_IS_DATA[idx_ff];
   assign rsp_tlast  = at_last;

endmodule

`default_nettype wire

// ===== hw/rtl/lcd_window_orientation_cmd_gen.sv =====
// A request passes through the input register, then the serializer's byte register,
// before its first response byte. Throughput: one byte per cycle while rsp_tready is high,
// limited by the single byte-wide response port; a set-window request sends 10 bytes and a
// set-direction request 12. A request is taken into the input register while the previous
// run drains. Synchronous active-high reset clears the valid flags and sets portrait.
`timescale 1ns / 1ps
`default_nettype none

module lcd_window_orientation_cmd_gen
   import lwo_pkg::*;
#(
   parameter logic [7:0] PANEL_COLS = DEF_PANEL_COLS,
   parameter logic [7:0] PANEL_ROWS = DEF_PANEL_ROWS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,  // x_start[7:0], y_start[15:8], win_width[31:16],
                                        // win_height[47:32], direction[55:48]
   input  wire logic        req_tuser,  // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // out_byte[7:0]
   output logic             rsp_tuser,  // is_data
   output logic             rsp_tlast   // last
);

   logic      in_valid_ff, in_valid_in;
   logic      func_ff, func_in;
   req_type   req_ff, req_in;
   logic      landscape_ff, landscape_in;
   logic      landscape_next, frame_take, req_fire;
   frame_type frame;

   assign req_tready = !in_valid_ff || frame_take;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      func_in      = func_ff;
      req_in       = req_ff;
      landscape_in = landscape_ff;
      if (frame_take) begin
         in_valid_in  = 1'b0;
         landscape_in = landscape_next;
      end
      if (req_fire) begin
         in_valid_in = 1'b1;
         func_in     = req_tuser;
         req_in      = {req_tdata[7:0], req_tdata[15:8], req_tdata[31:16],
                        req_tdata[47:32], req_tdata[55:48]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         landscape_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         landscape_ff <= landscape_in;
      end
      func_ff <= func_in;
      req_ff  <= req_in;
   end

   lwo_frame_build #(
      .PANEL_COLS (PANEL_COLS),
      .PANEL_ROWS (PANEL_ROWS)
   ) u_build (
      .func           (func_ff),
      .req            (req_ff),
      .landscape      (landscape_ff),
      .frame          (frame),
      .landscape_next (landscape_next)
   );

   lwo_byte_ser u_ser (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (in_valid_ff),
      .frame       (frame),
      .frame_take  (frame_take),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire
